/* rtl/hslhm_pkg.sv */
// shared types and constants for the hsl / heatmap to rgb565 converter
`default_nettype none

package hslhm_pkg;

  // input beat: one pixel request
  typedef struct packed {
    logic        mode;
    logic [11:0] hue;
    logic [12:0] saturation;
    logic [12:0] lightness;
    logic [15:0] distance;
  } hslhm_in_t;

  // output beat: packed color and the unpacked channels
  typedef struct packed {
    logic [15:0] color;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } hslhm_out_t;

  // request modes
  localparam logic MODE_HSL  = 1'b0;
  localparam logic MODE_HEAT = 1'b1;

  // configuration register indexes
  localparam int                  CFG_IDX_W      = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_LO    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_HI    = 2'd1;
  localparam logic [15:0]          MIN_DIST_RESET = 16'd0;
  localparam logic [15:0]          MAX_DIST_RESET = 16'd4000;

  // how the heatmap hue is formed
  typedef enum logic [1:0] {
    HEAT_SCALE,
    HEAT_ZERO,
    HEAT_FULL
  } hslhm_heat_t;

  // heatmap hue in degrees
  localparam logic [8:0] DEG_SECT    = 9'd60;
  localparam logic [8:0] DEG_TURN    = 9'd360;
  localparam logic [8:0] DEG_RED_OFS = 9'd120;
  localparam logic [8:0] DEG_BLU_OFS = 9'd240;
  localparam logic [7:0] HEAT_SPAN   = 8'd240;

  // pipelined divider for the heatmap hue
  localparam int NUM_W      = 24;
  localparam int DEN_W      = 16;
  localparam int QUOT_W     = 8;
  localparam int DIV_STAGES = 4;

endpackage

`default_nettype wire

/* rtl/hsl_heatmap_to_rgb565.sv */
// top level: hsl or distance heatmap request to rgb565 color, eight-stage pipeline
//
// Input channel in_valid / in_ready / in_data carries one request beat: mode 0
// converts hue, saturation and lightness (FRAC_BITS fraction bits), mode 1
// maps a distance between the low and high distance limits onto hue 0..240 deg.
// Output channel out_valid / out_ready / out_data returns one color beat per
// request, in request order, with the 565 word and the 8-bit channels.
// Configuration port cfg_valid / cfg_ready / cfg_index / cfg_data writes
// the low limit (index 0) and the high limit (index 1); cfg_ready is always high.
// Write registers only while no request is in flight.
// One beat per cycle is sustained while out_ready stays high. The eight
// pipeline stages are clamp, the l*s multiply, p/q, ramp selection, the
// per-channel multiply, sum, scale and the output register; the heatmap hue
// divider runs as four of those stages.
// Synchronous reset empties the pipeline and loads min 0 / max 4000.
// When the receiver stalls the whole pipeline holds; in_ready follows
// (not out_valid) or out_ready, so nothing is lost or repeated.
`default_nettype none

module hsl_heatmap_to_rgb565 #(
  parameter int FRAC_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  hslhm_pkg::hslhm_in_t               in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output hslhm_pkg::hslhm_out_t              out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [hslhm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                        cfg_data
);
  import hslhm_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int HB  = (F < 12) ? F : 12;
  localparam int XW  = (F + 1 > 13) ? F + 1 : 13;
  localparam int W2  = 2 * F + 2;
  localparam int WP  = 3 * F + 2;
  localparam int WM  = 3 * F + 10;
  localparam int UW  = F + 4;
  localparam int NST = 8;

  localparam logic [F:0]    ONE   = {1'b1, {F{1'b0}}};
  localparam logic [F:0]    HALF  = ONE >> 1;
  localparam logic [UW-1:0] SECT  = UW'(ONE);
  localparam logic [UW-1:0] SECT2 = SECT << 1;
  localparam logic [UW-1:0] SECT3 = UW'(SECT * 3);
  localparam logic [UW-1:0] SECT4 = SECT << 2;
  localparam logic [UW-1:0] TURN  = UW'(SECT * 6);

  // ramp position for one channel, mode 0 (one sixth of a turn is ONE)
  function automatic logic [F:0] ramp_t(input logic [UW-1:0] u);
    logic [UW-1:0] down;
    down = SECT4 - u;
    if (u < SECT) begin
      ramp_t = u[F:0];
    end else if (u < SECT3) begin
      ramp_t = ONE;
    end else if (u < SECT4) begin
      ramp_t = down[F:0];
    end else begin
      ramp_t = '0;
    end
  endfunction

  // ramp position for one channel, heatmap (one sixth of a turn is 60 deg)
  function automatic logic [5:0] heat_t(input logic [8:0] u);
    logic [8:0] down;
    down = DEG_BLU_OFS - u;
    if (u < DEG_SECT) begin
      heat_t = u[5:0];
    end else if (u < DEG_SECT * 3) begin
      heat_t = DEG_SECT[5:0];
    end else if (u < DEG_BLU_OFS) begin
      heat_t = down[5:0];
    end else begin
      heat_t = '0;
    end
  endfunction

  logic            adv;
  logic [NST-1:0]  vld_r;
  logic [15:0]     dist_lo_r;
  logic [15:0]     dist_hi_r;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_lo_r <= MIN_DIST_RESET;
      dist_hi_r <= MAX_DIST_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DIST_LO: dist_lo_r <= cfg_data;
        CFG_DIST_HI: dist_hi_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advances whenever the output register is free or being taken
  assign adv      = !vld_r[NST-1] || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // stage 1: clamp inputs, 6*hue, heatmap clamp and offset
  logic [F-1:0]    h_c;
  logic [XW-1:0]   sat_x;
  logic [XW-1:0]   lit_x;
  logic [F:0]      s_c;
  logic [F:0]      l_c;
  logic [15:0]     dist_c;
  hslhm_heat_t     heat_c;

  assign h_c   = F'(in_data.hue[HB-1:0]);
  assign sat_x = XW'(in_data.saturation);
  assign lit_x = XW'(in_data.lightness);
  assign s_c   = (sat_x > XW'(ONE)) ? ONE : sat_x[F:0];
  assign l_c   = (lit_x > XW'(ONE)) ? ONE : lit_x[F:0];

  always_comb begin
    if (in_data.distance < dist_lo_r) begin
      dist_c = dist_lo_r;
    end else if (in_data.distance > dist_hi_r) begin
      dist_c = dist_hi_r;
    end else begin
      dist_c = in_data.distance;
    end
    if (dist_lo_r == dist_hi_r) begin
      heat_c = HEAT_ZERO;
    end else if (dist_lo_r > dist_hi_r) begin
      heat_c = (in_data.distance < dist_lo_r) ? HEAT_ZERO : HEAT_FULL;
    end else begin
      heat_c = HEAT_SCALE;
    end
  end

  logic            mode_1_r;
  logic [UW-1:0]   h6_1_r;
  logic [F:0]      s_1_r;
  logic [F:0]      l_1_r;
  logic [15:0]     diff_1_r;
  hslhm_heat_t     heat_1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      mode_1_r <= in_data.mode;
      h6_1_r   <= UW'({h_c, 2'b00}) + UW'({h_c, 1'b0});
      s_1_r    <= s_c;
      l_1_r    <= l_c;
      diff_1_r <= dist_c - dist_lo_r;
      heat_1_r <= heat_c;
    end
  end

  // stage 2: l*s product, heatmap numerator times 240
  logic            mode_2_r;
  logic [UW-1:0]   h6_2_r;
  logic [F:0]      s_2_r;
  logic [F:0]      l_2_r;
  logic [W2-1:0]   ls_2_r;
  logic [NUM_W-1:0] num_2_r;
  hslhm_heat_t     heat_2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      mode_2_r <= mode_1_r;
      h6_2_r   <= h6_1_r;
      s_2_r    <= s_1_r;
      l_2_r    <= l_1_r;
      ls_2_r   <= W2'(l_1_r) * W2'(s_1_r);
      num_2_r  <= NUM_W'({diff_1_r, 8'h00}) - NUM_W'({diff_1_r, 4'h0});
      heat_2_r <= heat_1_r;
    end
  end

  // stages 3 to 6: heatmap hue = numerator / (max - min)
  logic [DEN_W-1:0]  den;
  logic [QUOT_W-1:0] quot_6;

  assign den = dist_hi_r - dist_lo_r;

  hslhm_div u_div (
    .clk  (clk),
    .en   (adv),
    .num  (num_2_r),
    .den  (den),
    .quot (quot_6)
  );

  // stage 3: q and p with 2F fraction bits
  logic [W2-1:0]   l_sh;
  logic [W2-1:0]   q2_c;
  logic [W2-1:0]   p2_c;
  logic [W2-1:0]   d2_c;

  assign l_sh = W2'(l_2_r) << F;
  assign q2_c = (l_2_r < HALF) ? l_sh + ls_2_r
                               : l_sh + (W2'(s_2_r) << F) - ls_2_r;
  assign p2_c = (l_sh << 1) - q2_c;
  assign d2_c = q2_c - p2_c;

  logic            mode_3_r;
  logic [UW-1:0]   h6_3_r;
  logic [2*F:0]    p2_3_r;
  logic [2*F:0]    d2_3_r;
  hslhm_heat_t     heat_3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      mode_3_r <= mode_2_r;
      h6_3_r   <= h6_2_r;
      p2_3_r   <= p2_c[2*F:0];
      d2_3_r   <= d2_c[2*F:0];
      heat_3_r <= heat_2_r;
    end
  end

  // stage 4: hue-shifted position and ramp value per channel
  logic [UW-1:0]   u_c [3];
  logic [UW-1:0]   ur_sum;
  logic [UW-1:0]   ub_sum;

  assign ur_sum = h6_3_r + SECT2;
  assign ub_sum = h6_3_r + SECT4;
  assign u_c[0] = (ur_sum >= TURN) ? ur_sum - TURN : ur_sum;
  assign u_c[1] = h6_3_r;
  assign u_c[2] = (ub_sum >= TURN) ? ub_sum - TURN : ub_sum;

  logic            mode_4_r;
  logic [F:0]      t_4_r [3];
  logic [2*F:0]    p2_4_r;
  logic [2*F:0]    d2_4_r;
  hslhm_heat_t     heat_4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      mode_4_r <= mode_3_r;
      for (int k = 0; k < 3; k++) begin
        t_4_r[k] <= ramp_t(u_c[k]);
      end
      p2_4_r   <= p2_3_r;
      d2_4_r   <= d2_3_r;
      heat_4_r <= heat_3_r;
    end
  end

  // stage 5: (q - p) times ramp position
  logic            mode_5_r;
  logic [WP-1:0]   prod_5_r [3];
  logic [2*F:0]    p2_5_r;
  hslhm_heat_t     heat_5_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      mode_5_r <= mode_4_r;
      for (int k = 0; k < 3; k++) begin
        prod_5_r[k] <= WP'(d2_4_r) * WP'(t_4_r[k]);
      end
      p2_5_r   <= p2_4_r;
      heat_5_r <= heat_4_r;
    end
  end

  // stage 6: add p back in, 3F fraction bits
  logic            mode_6_r;
  logic [WP-1:0]   sum_6_r [3];
  hslhm_heat_t     heat_6_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      mode_6_r <= mode_5_r;
      for (int k = 0; k < 3; k++) begin
        sum_6_r[k] <= (WP'(p2_5_r) << F) + prod_5_r[k];
      end
      heat_6_r <= heat_5_r;
    end
  end

  // stage 7: scale by 255 and truncate; heatmap hue and ramp positions
  logic [WM-1:0]   m255_c [3];
  logic [8:0]      hue_c;
  logic [8:0]      hr_sum;
  logic [8:0]      hb_sum;
  logic [8:0]      hu_c [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m255_c[k] = (WM'(sum_6_r[k]) << 8) - WM'(sum_6_r[k]);
    end
    case (heat_6_r)
      HEAT_SCALE: hue_c = 9'(quot_6);
      HEAT_ZERO:  hue_c = '0;
      HEAT_FULL:  hue_c = 9'(HEAT_SPAN);
      default:    hue_c = '0;
    endcase
  end

  assign hr_sum = hue_c + DEG_RED_OFS;
  assign hb_sum = hue_c + DEG_BLU_OFS;
  assign hu_c[0] = (hr_sum >= DEG_TURN) ? hr_sum - DEG_TURN : hr_sum;
  assign hu_c[1] = hue_c;
  assign hu_c[2] = (hb_sum >= DEG_TURN) ? hb_sum - DEG_TURN : hb_sum;

  logic            mode_7_r;
  logic [7:0]      ch0_7_r [3];
  logic [5:0]      th_7_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      mode_7_r <= mode_6_r;
      for (int k = 0; k < 3; k++) begin
        ch0_7_r[k] <= m255_c[k][3*F+7:3*F];
        th_7_r[k]  <= heat_t(hu_c[k]);
      end
    end
  end

  // stage 8: heatmap channel = floor(255 * t / 60), mode select, 565 pack
  logic [9:0]      h17_c [3];
  logic [7:0]      ch_c  [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      h17_c[k] = {th_7_r[k], 4'h0} + 10'(th_7_r[k]);
      ch_c[k]  = (mode_7_r == MODE_HEAT) ? h17_c[k][9:2] : ch0_7_r[k];
    end
  end

  hslhm_out_t out_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.color <= {ch_c[0][7:3], ch_c[1][7:2], ch_c[2][7:3]};
      out_r.red   <= ch_c[0];
      out_r.green <= ch_c[1];
      out_r.blue  <= ch_c[2];
    end
  end

  assign out_valid = vld_r[NST-1];
  assign out_data  = out_r;

endmodule

`default_nettype wire

/* rtl/hslhm_div.sv */
// pipelined restoring divider, two quotient bits per stage
`default_nettype none

module hslhm_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [hslhm_pkg::NUM_W-1:0]   num,
  input  logic [hslhm_pkg::DEN_W-1:0]   den,
  output logic [hslhm_pkg::QUOT_W-1:0]  quot
);
  import hslhm_pkg::*;

  localparam int BPS = QUOT_W / DIV_STAGES;

  logic [NUM_W-1:0]  rem_r [DIV_STAGES-1];
  logic [QUOT_W-1:0] q_r   [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [NUM_W-1:0]  rem_in;
    logic [NUM_W-1:0]  rem_out;
    logic [QUOT_W-1:0] q_in;
    logic [QUOT_W-1:0] q_out;

    // stage input comes from the request or the previous stage
    if (g == 0) begin : g_first
      assign rem_in = num;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[g-1];
      assign q_in   = q_r[g-1];
    end

    // trial subtract of the shifted divisor, one quotient bit per step
    always_comb begin : p_step
      logic [NUM_W:0]   trial;
      logic [NUM_W-1:0] rem;
      rem   = rem_in;
      q_out = q_in;
      for (int b = 0; b < BPS; b++) begin
        trial = {1'b0, rem} - ({1'b0, NUM_W'(den)} << (QUOT_W - 1 - g * BPS - b));
        if (!trial[NUM_W]) begin
          rem = trial[NUM_W-1:0];
          q_out[QUOT_W - 1 - g * BPS - b] = 1'b1;
        end
      end
      rem_out = rem;
    end

    // stage registers
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[g] <= q_out;
      end
    end

    if (g < DIV_STAGES - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[g] <= rem_out;
        end
      end
    end else begin : g_last
      logic unused_rem;
      assign unused_rem = ^rem_out;
    end
  end

  assign quot = q_r[DIV_STAGES-1];

endmodule

`default_nettype wire

/* rtl/hslhm_chk.sv */
// port-level checker for the converter, bound to the top level
`default_nettype none

module hslhm_chk (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_ready,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  hslhm_pkg::hslhm_out_t out_data
);
  import hslhm_pkg::*;

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  // a stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("out_data changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // input side is open whenever the output side is not stalled
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("in_ready low with output free");

  // 565 word matches the channels it came from
  a_pack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.color ==
      {out_data.red[7:3], out_data.green[7:2], out_data.blue[7:3]})
    else $error("rgb565 packing mismatch");

endmodule

bind hsl_heatmap_to_rgb565 hslhm_chk u_hslhm_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
